[hdl/pcs_pkg.sv]
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared widths, defaults and the queue entry type of the processor selector.
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

  localparam int CPU_W            = 3;
  localparam int UTIL_W           = 11;
  localparam int DEPTH_W          = 4;
  localparam int DEMAND_W         = UTIL_W + 1;
  localparam int NUM_CPUS_DEFAULT = 8;
  localparam int QUEUE_DEPTH      = 2;

  typedef struct packed {
    logic [CPU_W-1:0]   cpu;
    logic               idle_cand;
    logic               busy_fit;
    logic [UTIL_W-1:0]  capacity;
    logic [DEPTH_W-1:0] idle_depth;
    logic [UTIL_W-1:0]  cpu_util;
    logic [UTIL_W-1:0]  spare;
    logic               last;
  } pcs_entry_t;

endpackage

`default_nettype wire

[hdl/performance_cpu_selector_top.sv]
// ----------------------------------------------------------------------------
// performance_cpu_selector_top
// Picks a processor for a waking task from a stream of candidate items.
//
// Input channel (in_valid/in_ready): one candidate per item, last marks the
// final candidate of a selection. Output channel (out_valid/out_ready): one
// result item per selection, given after the last candidate.
// Throughput: one candidate per cycle; in_ready is high whenever the
// two-entry queue between the classifier and the tracker has room.
// When the queue is empty, the last candidate passes through the queue and
// then the output register before the result item appears.
// When the receiver stalls, the result is held in the output register; the
// tracker keeps consuming candidates of the next selection and stops only
// at that selection's last item, after which the queue fills and in_ready
// drops.
// Reset clears the queue, the trackers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module performance_cpu_selector_top
  import pcs_pkg::*;
#(
  parameter int NUM_CPUS = NUM_CPUS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CPU_W-1:0]   cpu_index,
  input  wire logic               eligible,
  input  wire logic               is_idle,
  input  wire logic [UTIL_W-1:0]  capacity,
  input  wire logic [DEPTH_W-1:0] idle_depth,
  input  wire logic [UTIL_W-1:0]  cpu_util,
  input  wire logic [UTIL_W-1:0]  task_util,
  input  wire logic [UTIL_W-1:0]  boosted_util,
  input  wire logic               last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CPU_W-1:0]        chosen_cpu,
  output logic                    found,
  output logic                    from_idle
);

  pcs_entry_t front_entry;
  pcs_entry_t head_entry;
  logic       q_full;
  logic       head_valid;
  logic       pop;

  assign in_ready = !q_full;

  pcs_front #(
    .NUM_CPUS(NUM_CPUS)
  ) u_front (
    .cpu_index   (cpu_index),
    .eligible    (eligible),
    .is_idle     (is_idle),
    .capacity    (capacity),
    .idle_depth  (idle_depth),
    .cpu_util    (cpu_util),
    .task_util   (task_util),
    .boosted_util(boosted_util),
    .last        (last),
    .entry       (front_entry)
  );

  pcs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_entry(front_entry),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_entry(head_entry)
  );

  pcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_entry(head_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .chosen_cpu(chosen_cpu),
    .found     (found),
    .from_idle (from_idle)
  );

endmodule

`default_nettype wire

[hdl/pcs_front.sv]
// ----------------------------------------------------------------------------
// pcs_front
// Classifies one candidate: range check, idle candidate, busy fit and spare.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_front
  import pcs_pkg::*;
#(
  parameter int NUM_CPUS = NUM_CPUS_DEFAULT
) (
  input  wire logic [CPU_W-1:0]   cpu_index,
  input  wire logic               eligible,
  input  wire logic               is_idle,
  input  wire logic [UTIL_W-1:0]  capacity,
  input  wire logic [DEPTH_W-1:0] idle_depth,
  input  wire logic [UTIL_W-1:0]  cpu_util,
  input  wire logic [UTIL_W-1:0]  task_util,
  input  wire logic [UTIL_W-1:0]  boosted_util,
  input  wire logic               last,
  output pcs_entry_t              entry
);

  localparam int IdxW = 8;

  logic                in_range;
  logic                elig;
  logic [DEMAND_W-1:0] sum;
  logic [DEMAND_W-1:0] demand;
  logic                fits;

  always_comb begin
    in_range = IdxW'(cpu_index) < IdxW'(NUM_CPUS);
    elig     = eligible && in_range;
    sum      = DEMAND_W'(cpu_util) + DEMAND_W'(task_util);
    demand   = (DEMAND_W'(boosted_util) > sum) ? DEMAND_W'(boosted_util) : sum;
    fits     = demand <= DEMAND_W'(capacity);

    entry.cpu        = cpu_index;
    entry.idle_cand  = elig && is_idle;
    entry.busy_fit   = elig && !is_idle && fits;
    entry.capacity   = capacity;
    entry.idle_depth = idle_depth;
    entry.cpu_util   = cpu_util;
    entry.spare      = capacity - cpu_util;
    entry.last       = last;
  end

endmodule

`default_nettype wire

[hdl/pcs_queue.sv]
// ----------------------------------------------------------------------------
// pcs_queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_queue
  import pcs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire pcs_entry_t push_entry,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output pcs_entry_t      head_entry
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  pcs_entry_t       mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full       = count == CntW'(DEPTH);
  assign head_valid = count != '0;
  assign head_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/pcs_back.sv]
// ----------------------------------------------------------------------------
// pcs_back
// Updates the idle and backup trackers and registers the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_back
  import pcs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire pcs_entry_t       head_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [CPU_W-1:0]      chosen_cpu,
  output logic                  found,
  output logic                  from_idle
);

  logic               idle_valid;
  logic [UTIL_W-1:0]  best_capacity;
  logic [DEPTH_W-1:0] best_depth;
  logic [UTIL_W-1:0]  best_util;
  logic [CPU_W-1:0]   best_idle_num;
  logic               backup_valid;
  logic [UTIL_W-1:0]  max_spare;
  logic [CPU_W-1:0]   backup_cpu_reg;

  logic               take_idle;
  logic               take_backup;
  logic               idle_valid_next;
  logic [CPU_W-1:0]   best_idle_num_next;
  logic               backup_valid_next;
  logic [CPU_W-1:0]   backup_cpu_next;
  logic               emit;

  always_comb begin
    pop  = head_valid && (!head_entry.last || !out_valid || out_ready);
    emit = pop && head_entry.last;

    take_idle = head_entry.idle_cand &&
                (!idle_valid || head_entry.capacity > best_capacity ||
                 (head_entry.capacity == best_capacity &&
                  (head_entry.idle_depth < best_depth ||
                   (head_entry.idle_depth == best_depth &&
                    head_entry.cpu_util < best_util))));
    take_backup = head_entry.busy_fit &&
                  (!backup_valid || head_entry.spare >= max_spare);

    idle_valid_next    = idle_valid || take_idle;
    best_idle_num_next = take_idle ? head_entry.cpu : best_idle_num;
    backup_valid_next  = backup_valid || take_backup;
    backup_cpu_next    = take_backup ? head_entry.cpu : backup_cpu_reg;
  end

  always_ff @(posedge clk) begin
    if (rst || emit) begin
      idle_valid     <= 1'b0;
      best_capacity  <= '0;
      best_depth     <= '0;
      best_util      <= '0;
      best_idle_num  <= '0;
      backup_valid   <= 1'b0;
      max_spare      <= '0;
      backup_cpu_reg <= '0;
    end else if (pop) begin
      if (take_idle) begin
        idle_valid    <= 1'b1;
        best_capacity <= head_entry.capacity;
        best_depth    <= head_entry.idle_depth;
        best_util     <= head_entry.cpu_util;
        best_idle_num <= head_entry.cpu;
      end
      if (take_backup) begin
        backup_valid   <= 1'b1;
        max_spare      <= head_entry.spare;
        backup_cpu_reg <= head_entry.cpu;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      chosen_cpu <= '0;
      found      <= 1'b0;
      from_idle  <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      if (idle_valid_next) begin
        chosen_cpu <= best_idle_num_next;
        found      <= 1'b1;
        from_idle  <= 1'b1;
      end else if (backup_valid_next) begin
        chosen_cpu <= backup_cpu_next;
        found      <= 1'b1;
        from_idle  <= 1'b0;
      end else begin
        chosen_cpu <= '0;
        found      <= 1'b0;
        from_idle  <= 1'b0;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hdl/pcs_checker.sv]
// ----------------------------------------------------------------------------
// pcs_checker
// Port-level checks of the processor selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_checker
  import pcs_pkg::*;
#(
  parameter int NUM_CPUS = NUM_CPUS_DEFAULT
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [CPU_W-1:0] chosen_cpu,
  input wire logic             found,
  input wire logic             from_idle
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(chosen_cpu) && $stable(found) && $stable(from_idle))
    else $error("result payload changed while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> !from_idle && chosen_cpu == '0)
    else $error("not-found result carries a choice");

  a_cpu_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> 32'(chosen_cpu) < NUM_CPUS)
    else $error("chosen processor out of range");

endmodule

bind performance_cpu_selector_top pcs_checker #(
  .NUM_CPUS(NUM_CPUS)
) u_pcs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .chosen_cpu(chosen_cpu),
  .found     (found),
  .from_idle (from_idle)
);

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for performance_cpu_selector_top. Candidate items go
// in through a bursty sender while the result side stalls on its own
// pattern. Each accepted item updates a local copy of the idle and backup
// trackers, and each last item queues the pick that must come out. Results
// are checked field by field against that queue in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import pcs_pkg::*;

  localparam int NCPU = NUM_CPUS_DEFAULT;

  typedef struct packed {
    logic [CPU_W-1:0]   cpu;
    logic               elig;
    logic               idle;
    logic [UTIL_W-1:0]  cap;
    logic [DEPTH_W-1:0] depth;
    logic [UTIL_W-1:0]  cutil;
    logic [UTIL_W-1:0]  tutil;
    logic [UTIL_W-1:0]  butil;
    logic               last;
  } cand_t;

  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    logic             found;
    logic             from_idle;
  } pick_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [CPU_W-1:0]   cpu_index;
  logic               eligible;
  logic               is_idle;
  logic [UTIL_W-1:0]  capacity;
  logic [DEPTH_W-1:0] idle_depth;
  logic [UTIL_W-1:0]  cpu_util;
  logic [UTIL_W-1:0]  task_util;
  logic [UTIL_W-1:0]  boosted_util;
  logic               last;
  logic               out_valid;
  logic               out_ready;
  logic [CPU_W-1:0]   chosen_cpu;
  logic               found;
  logic               from_idle;

  performance_cpu_selector_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cpu_index    (cpu_index),
    .eligible     (eligible),
    .is_idle      (is_idle),
    .capacity     (capacity),
    .idle_depth   (idle_depth),
    .cpu_util     (cpu_util),
    .task_util    (task_util),
    .boosted_util (boosted_util),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .chosen_cpu   (chosen_cpu),
    .found        (found),
    .from_idle    (from_idle)
  );

  // local copy of the trackers
  logic               idle_ok;
  logic [UTIL_W-1:0]  idle_cap;
  logic [DEPTH_W-1:0] idle_dep;
  logic [UTIL_W-1:0]  idle_util;
  logic [CPU_W-1:0]   idle_sel;
  logic               bk_ok;
  logic [UTIL_W-1:0]  bk_spare;
  logic [CPU_W-1:0]   bk_cpu;

  pick_t pending_picks[$];

  int errors;
  int n_items;
  int n_sel;
  int n_idle_pick;
  int n_bk_pick;
  int n_none;
  int burst_left;
  bit gaps_on;
  bit force_ready;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic void clear_trackers();
    idle_ok   = 1'b0;
    idle_cap  = '0;
    idle_dep  = '0;
    idle_util = '0;
    idle_sel  = '0;
    bk_ok     = 1'b0;
    bk_spare  = '0;
    bk_cpu    = '0;
  endfunction

  function automatic void update_selection(cand_t c);
    logic [DEMAND_W-1:0] demand;
    logic [UTIL_W-1:0]   spare;
    logic                take;
    logic                ok;
    pick_t               p;
    ok = c.elig && (int'(c.cpu) < NCPU);
    if (ok && c.idle) begin
      if (!idle_ok || c.cap > idle_cap) take = 1'b1;
      else if (c.cap < idle_cap) take = 1'b0;
      else if (c.depth < idle_dep) take = 1'b1;
      else if (c.depth > idle_dep) take = 1'b0;
      else take = c.cutil < idle_util;
      if (take) begin
        idle_ok   = 1'b1;
        idle_cap  = c.cap;
        idle_dep  = c.depth;
        idle_util = c.cutil;
        idle_sel  = c.cpu;
      end
    end else if (ok) begin
      demand = {1'b0, c.cutil} + {1'b0, c.tutil};
      if ({1'b0, c.butil} > demand) demand = {1'b0, c.butil};
      if (demand <= {1'b0, c.cap}) begin
        spare = c.cap - c.cutil;
        if (!bk_ok || spare >= bk_spare) begin
          bk_ok    = 1'b1;
          bk_spare = spare;
          bk_cpu   = c.cpu;
        end
      end
    end
    if (c.last) begin
      n_sel++;
      if (idle_ok) begin
        p = '{cpu: idle_sel, found: 1'b1, from_idle: 1'b1};
        n_idle_pick++;
      end else if (bk_ok) begin
        p = '{cpu: bk_cpu, found: 1'b1, from_idle: 1'b0};
        n_bk_pick++;
      end else begin
        p = '{cpu: '0, found: 1'b0, from_idle: 1'b0};
        n_none++;
      end
      pending_picks.push_back(p);
      clear_trackers();
    end
  endfunction

  function automatic cand_t mk(int cpu, int el, int idl, int cap, int dep,
                               int cu, int tu, int bu, int lst);
    cand_t c;
    c.cpu   = cpu[CPU_W-1:0];
    c.elig  = el[0];
    c.idle  = idl[0];
    c.cap   = cap[UTIL_W-1:0];
    c.depth = dep[DEPTH_W-1:0];
    c.cutil = cu[UTIL_W-1:0];
    c.tutil = tu[UTIL_W-1:0];
    c.butil = bu[UTIL_W-1:0];
    c.last  = lst[0];
    return c;
  endfunction

  function automatic cand_t rand_cand(bit is_last);
    int cap;
    int cu;
    int tu;
    int bu;
    int dep;
    int room;
    case ($urandom_range(0, 4))
      0, 1:    cap = 1024;
      2:       cap = 512;
      3:       cap = 768;
      default: cap = $urandom_range(0, 1024);
    endcase
    dep = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(0, 15);
    case ($urandom_range(0, 6))
      0:       cu = $urandom_range(0, 2047);
      1, 2:    cu = $urandom_range(0, 1) ? 0 : cap / 2;
      default: cu = $urandom_range(0, cap);
    endcase
    room = (cu <= cap) ? cap - cu : 0;
    tu = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, room);
    bu = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, cap);
    return mk($urandom_range(0, 7), $urandom_range(0, 9) != 0, $urandom_range(0, 1),
              cap, dep, cu, tu, bu, is_last);
  endfunction

  task automatic send_cand(cand_t c);
    if (gaps_on && burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    cpu_index    <= c.cpu;
    eligible     <= c.elig;
    is_idle      <= c.idle;
    capacity     <= c.cap;
    idle_depth   <= c.depth;
    cpu_util     <= c.cutil;
    task_util    <= c.tutil;
    boosted_util <= c.butil;
    last         <= c.last;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    update_selection(c);
    n_items++;
    burst_left--;
  endtask

  task automatic wait_all_picks();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_picks.size() != 0) @(posedge clk);
  endtask

  task automatic send_selection();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
    for (int i = 0; i < n; i++) send_cand(rand_cand(i == n - 1));
  endtask

  task automatic test_directed();
    // lone candidates: extremes and no-fit cases
    send_cand(mk(7, 1, 1, 0, 15, 2047, 1024, 2047, 1));
    send_cand(mk(3, 1, 0, 1024, 0, 1024, 0, 0, 1));
    send_cand(mk(5, 1, 0, 1024, 0, 2047, 1024, 0, 1));
    send_cand(mk(2, 1, 0, 1024, 0, 0, 0, 2047, 1));
    send_cand(mk(1, 0, 1, 1024, 0, 0, 0, 0, 1));
    // idle ranking: capacity, depth, util, full tie keeps earlier
    send_cand(mk(0, 1, 1, 512, 3, 100, 0, 0, 0));
    send_cand(mk(1, 1, 1, 1024, 5, 900, 0, 0, 0));
    send_cand(mk(2, 1, 1, 1024, 2, 1000, 0, 0, 0));
    send_cand(mk(3, 1, 1, 1024, 2, 10, 0, 0, 0));
    send_cand(mk(4, 1, 1, 1024, 2, 10, 0, 0, 1));
    // backup: spare tie goes to later, ineligible ignored, no-fit last
    send_cand(mk(6, 1, 0, 1024, 0, 24, 100, 0, 0));
    send_cand(mk(1, 1, 0, 1024, 0, 24, 100, 0, 0));
    send_cand(mk(2, 1, 0, 512, 0, 0, 0, 0, 0));
    send_cand(mk(7, 0, 1, 1024, 0, 0, 0, 0, 0));
    send_cand(mk(0, 1, 0, 1024, 0, 1000, 100, 0, 1));
    // idle beats backup
    send_cand(mk(5, 1, 0, 800, 0, 0, 0, 0, 0));
    send_cand(mk(6, 1, 1, 0, 0, 0, 0, 0, 1));
    // boosted demand exactly at capacity
    send_cand(mk(4, 1, 0, 700, 0, 100, 50, 700, 1));
    wait_all_picks();
  endtask

  task automatic test_random_selections(int target);
    int stop_at;
    stop_at = n_items + target;
    while (n_items < stop_at) send_selection();
  endtask

  task automatic test_pause_between();
    repeat (6) begin
      repeat ($urandom_range(1, 4)) send_selection();
      wait_all_picks();
    end
  endtask

  task automatic test_back_to_back(int target);
    int stop_at;
    gaps_on     = 1'b0;
    force_ready = 1'b1;
    stop_at = n_items + target;
    while (n_items < stop_at) send_selection();
    gaps_on     = 1'b1;
    force_ready = 1'b0;
  endtask

  // receiver: ready pattern changes mode at random, with a new mode and period each time
  initial begin
    int left;
    int mode;
    int per;
    int ph;
    out_ready = 1'b0;
    left = 0;
    mode = 0;
    per  = 2;
    ph   = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(32, 200);
        per  = $urandom_range(2, 9);
      end
      left--;
      ph++;
      if (force_ready) out_ready <= 1'b1;
      else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((ph % per) == 0);
        endcase
      end
    end
  end

  // result checker
  initial begin
    pick_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
        if (pending_picks.size() == 0) begin
          errors++;
          $display("%0t: unexpected result cpu=%0d found=%0d from_idle=%0d",
                   $time, chosen_cpu, found, from_idle);
        end else begin
          want = pending_picks.pop_front();
          if (found !== want.found) begin
            errors++;
            $display("%0t: found exp=%0d got=%0d", $time, want.found, found);
          end
          if (from_idle !== want.from_idle) begin
            errors++;
            $display("%0t: from_idle exp=%0d got=%0d", $time, want.from_idle, from_idle);
          end
          if (chosen_cpu !== want.cpu) begin
            errors++;
            $display("%0t: chosen_cpu exp=%0d got=%0d", $time, want.cpu, chosen_cpu);
          end
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    cpu_index    = '0;
    eligible     = 1'b0;
    is_idle      = 1'b0;
    capacity     = '0;
    idle_depth   = '0;
    cpu_util     = '0;
    task_util    = '0;
    boosted_util = '0;
    last         = 1'b0;
    errors       = 0;
    n_items      = 0;
    n_sel        = 0;
    n_idle_pick  = 0;
    n_bk_pick    = 0;
    n_none       = 0;
    burst_left   = 0;
    gaps_on      = 1'b1;
    force_ready  = 1'b0;
    clear_trackers();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_selections(900);
    test_pause_between();
    test_back_to_back(200);
    test_random_selections(900);

    wait_all_picks();
    repeat (8) @(posedge clk);
    $display("tb: %0d candidates in %0d selections", n_items, n_sel);
    $display("tb: picks %0d idle, %0d backup, %0d not found", n_idle_pick, n_bk_pick, n_none);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
